>>> rtl/tt_pkg.sv
`default_nettype none

package tt_pkg;

    // Scanner modes between text bytes.
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_WORD,
        MODE_QUOTE
    } tt_mode_t;

    // Character codes that the scanner looks for.
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] SPACE_LIMIT = 8'd32;

    // Depth of the queue between the scanner and the output stage.
    localparam int QUEUE_DEPTH = 4;

    // One result as it leaves the block, without the last marker.
    typedef struct packed {
        logic       has_char;
        logic [7:0] char_out;
        logic       token_done;
        logic [6:0] token_len;
        logic       discarded;
        logic       text_done;
    } tt_result_t;

    // All results caused by one text byte. A second result, when present,
    // always carries a plain token character.
    typedef struct packed {
        tt_result_t res0;
        logic       two;
        logic [7:0] char2;
    } tt_entry_t;

endpackage

`default_nettype wire

>>> rtl/tt_if.sv
`default_nettype none

// Text byte channel.
interface tt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

// Token result channel.
interface tt_out_if;
    logic       valid;
    logic       ready;
    logic       has_char;
    logic [7:0] char_out;
    logic       token_done;
    logic [6:0] token_len;
    logic       discarded;
    logic       text_done;
    logic       last;

    modport source (output valid, output has_char, output char_out, output token_done,
                    output token_len, output discarded, output text_done, output last,
                    input ready);
    modport sink (input valid, input has_char, input char_out, input token_done,
                  input token_len, input discarded, input text_done, input last,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/tt_front.sv
`default_nettype none

module tt_front
    import tt_pkg::*;
#(
    parameter int MAX_TOKEN = 128
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tt_in_if.sink      text_in,
    input  wire logic  full,
    output logic       push,
    output tt_entry_t  entry
);

    localparam int CW = $clog2(MAX_TOKEN + 1);
    localparam int LW = CW + 7;
    localparam logic [CW-1:0] KEEP_MAX   = CW'(MAX_TOKEN);
    localparam logic [CW-1:0] QUOTE_MAX  = CW'(MAX_TOKEN - 1);
    localparam logic [CW-1:0] KEPT_ONE   = CW'(1);
    localparam logic [CW-1:0] KEPT_TWO   = CW'(2);

    tt_mode_t      mode_reg, mode_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic [LW-1:0] kept_ext;
    logic [6:0]    kept_len;
    logic [7:0]    c;
    logic          is_space;
    logic          is_nul;
    logic          accept;
    logic          produce;
    tt_entry_t     ent;

    assign c        = text_in.char_in;
    assign is_space = (c <= SPACE_LIMIT) || c[7];
    assign is_nul   = (c == CH_NUL);
    assign kept_ext = LW'(kept_reg);
    assign kept_len = kept_ext[6:0];

    // A byte is taken whenever the queue has room for its results.
    assign text_in.ready = !full;
    assign accept        = text_in.valid && !full;
    assign push          = accept && produce;
    assign entry         = ent;

    // Next scanner mode and kept character count.
    always_comb
    begin
        mode_next = mode_reg;
        kept_next = kept_reg;
        case (mode_reg)
            MODE_SLASH:
            begin
                if (c == CH_SLASH)
                begin
                    mode_next = MODE_COMMENT;
                end
                else if (is_space)
                begin
                    mode_next = MODE_IDLE;
                    kept_next = '0;
                end
                else
                begin
                    mode_next = MODE_WORD;
                    kept_next = KEPT_TWO;
                end
            end
            MODE_COMMENT:
            begin
                if (is_nul || c == CH_NEWLINE)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_WORD:
            begin
                if (is_space)
                begin
                    mode_next = MODE_IDLE;
                    kept_next = '0;
                end
                else if (kept_reg < KEEP_MAX)
                begin
                    kept_next = kept_reg + KEPT_ONE;
                end
            end
            MODE_QUOTE:
            begin
                if (c == CH_QUOTE || is_nul)
                begin
                    mode_next = MODE_IDLE;
                    kept_next = '0;
                end
                else if (kept_reg < QUOTE_MAX)
                begin
                    kept_next = kept_reg + KEPT_ONE;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                kept_next = '0;
                if (is_space)
                begin
                    mode_next = MODE_IDLE;
                end
                else if (c == CH_SLASH)
                begin
                    mode_next = MODE_SLASH;
                end
                else if (c == CH_QUOTE)
                begin
                    mode_next = MODE_QUOTE;
                end
                else
                begin
                    mode_next = MODE_WORD;
                    kept_next = KEPT_ONE;
                end
            end
        endcase
    end

    // Results caused by the current byte.
    always_comb
    begin
        ent     = '0;
        produce = 1'b0;
        case (mode_reg)
            MODE_SLASH:
            begin
                if (c != CH_SLASH)
                begin
                    produce                = 1'b1;
                    ent.res0.has_char      = 1'b1;
                    ent.res0.char_out      = CH_SLASH;
                    if (is_space)
                    begin
                        ent.res0.token_done = 1'b1;
                        ent.res0.token_len  = 7'd1;
                        ent.res0.text_done  = is_nul;
                    end
                    else
                    begin
                        ent.two   = 1'b1;
                        ent.char2 = c;
                    end
                end
            end
            MODE_COMMENT:
            begin
                if (is_nul)
                begin
                    produce            = 1'b1;
                    ent.res0.text_done = 1'b1;
                end
            end
            MODE_WORD:
            begin
                if (is_space)
                begin
                    produce             = 1'b1;
                    ent.res0.token_done = 1'b1;
                    ent.res0.discarded  = (kept_reg >= KEEP_MAX);
                    ent.res0.token_len  = (kept_reg >= KEEP_MAX) ? 7'd0 : kept_len;
                    ent.res0.text_done  = is_nul;
                end
                else if (kept_reg < KEEP_MAX)
                begin
                    produce           = 1'b1;
                    ent.res0.has_char = 1'b1;
                    ent.res0.char_out = c;
                end
            end
            MODE_QUOTE:
            begin
                if (c == CH_QUOTE || is_nul)
                begin
                    produce             = 1'b1;
                    ent.res0.token_done = 1'b1;
                    ent.res0.token_len  = kept_len;
                    ent.res0.text_done  = is_nul;
                end
                else if (kept_reg < QUOTE_MAX)
                begin
                    produce           = 1'b1;
                    ent.res0.has_char = 1'b1;
                    ent.res0.char_out = c;
                end
            end
            default:
            begin
                if (is_nul)
                begin
                    produce            = 1'b1;
                    ent.res0.text_done = 1'b1;
                end
                else if (!is_space && c != CH_SLASH && c != CH_QUOTE)
                begin
                    produce           = 1'b1;
                    ent.res0.has_char = 1'b1;
                    ent.res0.char_out = c;
                end
            end
        endcase
    end

    // Scanner state advances on every accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            kept_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            kept_reg <= kept_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tt_queue.sv
`default_nettype none

module tt_queue
    import tt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire tt_entry_t  push_entry,
    input  wire logic       pop,
    output tt_entry_t       head,
    output logic            full,
    output logic            empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_ONE   = PW'(1);
    localparam logic [NW-1:0] COUNT_ONE = NW'(1);
    localparam logic [NW-1:0] COUNT_MAX = NW'(QUEUE_DEPTH);

    tt_entry_t     slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full    = (count_reg == COUNT_MAX);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    // Pointers and fill count; the depth is a power of two so pointers wrap.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_ONE;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_ONE;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + COUNT_ONE;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - COUNT_ONE;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tt_back.sv
`default_nettype none

module tt_back
    import tt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire tt_entry_t  head,
    input  wire logic       empty,
    output logic            pop,
    tt_out_if.source        token_out
);

    logic       out_valid_reg, out_valid_next;
    tt_result_t out_res_reg, out_res_next;
    logic       out_last_reg, out_last_next;
    logic       phase_reg, phase_next;
    logic       load;
    logic       take;
    tt_result_t second;

    // The second result of a pair is always a plain token character.
    always_comb
    begin
        second          = '0;
        second.has_char = 1'b1;
        second.char_out = head.char2;
    end

    assign load = !out_valid_reg || token_out.ready;
    assign take = load && !empty;

    // Pick the next result from the queue head; a pair takes two turns.
    always_comb
    begin
        pop           = 1'b0;
        phase_next    = phase_reg;
        out_res_next  = head.res0;
        out_last_next = 1'b1;
        if (take)
        begin
            if (head.two && !phase_reg)
            begin
                out_last_next = 1'b0;
                phase_next    = 1'b1;
            end
            else if (head.two)
            begin
                out_res_next = second;
                pop          = 1'b1;
                phase_next   = 1'b0;
            end
            else
            begin
                pop = 1'b1;
            end
        end
    end

    assign out_valid_next = take ? 1'b1 : (token_out.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_res_reg  <= out_res_next;
            out_last_reg <= out_last_next;
        end
    end

    assign token_out.valid      = out_valid_reg;
    assign token_out.has_char   = out_res_reg.has_char;
    assign token_out.char_out   = out_res_reg.char_out;
    assign token_out.token_done = out_res_reg.token_done;
    assign token_out.token_len  = out_res_reg.token_len;
    assign token_out.discarded  = out_res_reg.discarded;
    assign token_out.text_done  = out_res_reg.text_done;
    assign token_out.last       = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/text_tokenizer_with_comments_top.sv
`default_nettype none

// Streaming tokenizer: text bytes go in one per request and token characters
// come out one per request, each token closed by a result that carries its
// kept length. The scanner takes one byte every cycle while its four-entry
// result queue has room, and the output stage delivers one result per cycle
// while the receiver is ready, so the sustained rate is one byte per cycle
// then. The only byte that causes two results is the one after a lone leading
// slash; the output stage hands out its two results one after the other. An
// accepted byte's results pass through the queue and then the output register.
module text_tokenizer_with_comments_top
    import tt_pkg::*;
#(
    parameter int MAX_TOKEN = 128
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tt_in_if.sink      text_in,
    tt_out_if.source   token_out
);

    logic      push;
    logic      pop;
    logic      full;
    logic      empty;
    tt_entry_t push_entry;
    tt_entry_t head;

    // Scanner: classifies each byte and updates the token state.
    tt_front #(
        .MAX_TOKEN (MAX_TOKEN)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .text_in (text_in),
        .full    (full),
        .push    (push),
        .entry   (push_entry)
    );

    // Result queue between scanner and output stage.
    tt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    // Output stage: splits pairs and marks the last result of each byte.
    tt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .token_out (token_out)
    );

endmodule

`default_nettype wire

>>> sim/tb.sv
`default_nettype none

module tb;
    import tt_pkg::*;

    localparam int TOKEN_MAX   = 128;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 100;
    localparam int PHASE_BYTES = 500;
    localparam int DRAIN_WAIT  = 8;

    // One expected token result together with its last marker.
    typedef struct packed {
        tt_result_t res;
        logic       last;
    } token_result_t;

    logic clk;
    logic rst_n;

    tt_in_if  text_if ();
    tt_out_if token_if ();

    text_tokenizer_with_comments_top #(
        .MAX_TOKEN (TOKEN_MAX)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_if),
        .token_out (token_if)
    );

    // Text bytes still to be offered, and token results still to arrive.
    logic [7:0]    text_q [$];
    token_result_t token_q [$];

    // Scanner state as the predictor tracks it.
    tt_mode_t    scan_mode;
    int unsigned kept_count;
    tt_result_t  byte_results [2];
    int          byte_result_cnt;

    int issued_cnt;
    int accepted_cnt;
    int result_cnt;
    int mismatch_cnt;
    int cycle_cnt;
    int src_idle_pct;
    int snk_idle_pct;

    // Clock with a period of 4.
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic is_blank(logic [7:0] c);
        return (c <= SPACE_LIMIT) || c[7];
    endfunction

    function automatic tt_result_t make_result(logic has, logic [7:0] ch, logic done,
                                               int unsigned len, logic disc, logic txt);
        tt_result_t r;
        r.has_char   = has;
        r.char_out   = ch;
        r.token_done = done;
        r.token_len  = 7'(len);
        r.discarded  = disc;
        r.text_done  = txt;
        return r;
    endfunction

    function void add_result(tt_result_t r);
        byte_results[byte_result_cnt] = r;
        byte_result_cnt++;
    endfunction

    // A byte inside a word: keep it while there is room, or close the word on
    // whitespace or NUL. A word that filled up is flagged for dropping.
    function void continue_word(logic [7:0] c);
        logic full;
        full = (kept_count >= TOKEN_MAX);
        if (!is_blank(c))
        begin
            if (!full)
            begin
                kept_count++;
                add_result(make_result(1'b1, c, 1'b0, 0, 1'b0, 1'b0));
            end
        end
        else
        begin
            add_result(make_result(1'b0, CH_NUL, 1'b1, full ? 0 : kept_count, full,
                                   c == CH_NUL));
            scan_mode  = MODE_IDLE;
            kept_count = 0;
        end
    endfunction

    // Work out the results of one accepted text byte and queue them.
    function void predict_tokens(logic [7:0] c);
        token_result_t item;
        byte_result_cnt = 0;
        case (scan_mode)
            MODE_SLASH:
            begin
                if (c == CH_SLASH)
                    scan_mode = MODE_COMMENT;
                else if (is_blank(c))
                begin
                    // A lone slash followed by whitespace is a one-character word.
                    add_result(make_result(1'b1, CH_SLASH, 1'b1, 1, 1'b0, c == CH_NUL));
                    scan_mode  = MODE_IDLE;
                    kept_count = 0;
                end
                else
                begin
                    scan_mode  = MODE_WORD;
                    kept_count = 1;
                    add_result(make_result(1'b1, CH_SLASH, 1'b0, 0, 1'b0, 1'b0));
                    continue_word(c);
                end
            end
            MODE_COMMENT:
            begin
                if (c == CH_NUL)
                begin
                    add_result(make_result(1'b0, CH_NUL, 1'b0, 0, 1'b0, 1'b1));
                    scan_mode = MODE_IDLE;
                end
                else if (c == CH_NEWLINE)
                    scan_mode = MODE_IDLE;
            end
            MODE_WORD:
                continue_word(c);
            MODE_QUOTE:
            begin
                if (c == CH_QUOTE || c == CH_NUL)
                begin
                    add_result(make_result(1'b0, CH_NUL, 1'b1, kept_count, 1'b0,
                                           c == CH_NUL));
                    scan_mode  = MODE_IDLE;
                    kept_count = 0;
                end
                else if (kept_count < TOKEN_MAX - 1)
                begin
                    kept_count++;
                    add_result(make_result(1'b1, c, 1'b0, 0, 1'b0, 1'b0));
                end
            end
            default:
            begin
                scan_mode  = MODE_IDLE;
                kept_count = 0;
                if (c == CH_NUL)
                    add_result(make_result(1'b0, CH_NUL, 1'b0, 0, 1'b0, 1'b1));
                else if (is_blank(c))
                    scan_mode = MODE_IDLE;
                else if (c == CH_SLASH)
                    scan_mode = MODE_SLASH;
                else if (c == CH_QUOTE)
                    scan_mode = MODE_QUOTE;
                else
                begin
                    scan_mode = MODE_WORD;
                    continue_word(c);
                end
            end
        endcase
        for (int i = 0; i < byte_result_cnt; i++)
        begin
            item.res  = byte_results[i];
            item.last = (i == byte_result_cnt - 1);
            token_q.push_back(item);
        end
    endfunction

    function automatic logic [7:0] blank_char();
        if ($urandom_range(1) == 0)
            return 8'($urandom_range(1, 32));
        return 8'($urandom_range(128, 255));
    endfunction

    function automatic logic [7:0] word_char();
        return 8'($urandom_range(33, 127));
    endfunction

    // Any byte but NUL and the one given.
    function automatic logic [7:0] char_except(logic [7:0] avoid);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == avoid);
        return c;
    endfunction

    // Mostly short token lengths, now and then one around the size limit.
    function automatic int token_length(int short_max);
        if ($urandom_range(39) == 0)
            return $urandom_range(TOKEN_MAX - 4, TOKEN_MAX + 3);
        return $urandom_range(1, short_max);
    endfunction

    // Append one random text fragment and return the number of bytes added.
    function automatic int append_fragment();
        int         start;
        int         len;
        int         pick;
        logic [7:0] c;
        start = text_q.size();
        pick  = $urandom_range(99);
        if (pick < 30 || (pick >= 70 && pick < 78))
        begin
            // A word, or a word behind a lone slash.
            if (pick >= 70)
                text_q.push_back(CH_SLASH);
            len = token_length(10);
            do
                c = word_char();
            while (c == CH_SLASH || c == CH_QUOTE);
            text_q.push_back(c);
            for (int i = 1; i < len; i++)
                text_q.push_back(word_char());
            text_q.push_back($urandom_range(9) == 0 ? CH_NUL : blank_char());
        end
        else if (pick < 45)
        begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
                text_q.push_back(blank_char());
        end
        else if (pick < 60)
        begin
            // A quoted token, sometimes empty, closed by a quote or a NUL.
            text_q.push_back(CH_QUOTE);
            len = ($urandom_range(7) == 0) ? 0 : token_length(12);
            for (int i = 0; i < len; i++)
                text_q.push_back(char_except(CH_QUOTE));
            text_q.push_back($urandom_range(7) == 0 ? CH_NUL : CH_QUOTE);
        end
        else if (pick < 70)
        begin
            text_q.push_back(CH_SLASH);
            text_q.push_back(CH_SLASH);
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++)
                text_q.push_back(char_except(CH_NEWLINE));
            text_q.push_back($urandom_range(7) == 0 ? CH_NUL : CH_NEWLINE);
        end
        else if (pick < 83)
            text_q.push_back(CH_NUL);
        else
        begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
                text_q.push_back(8'($urandom_range(0, 255)));
        end
        return text_q.size() - start;
    endfunction

    // Printing stops after a while so that a broken block does not flood the log.
    task automatic report_mismatch(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_LIMIT)
            $display("mismatch at result %0d: %s", result_cnt, msg);
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Sender: offer the next text byte once the previous request was taken.
    always @(negedge clk)
    begin
        if (rst_n && accepted_cnt == issued_cnt)
        begin
            if (text_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                text_if.valid   <= 1'b1;
                text_if.char_in <= text_q.pop_front();
                issued_cnt++;
            end
            else
                text_if.valid <= 1'b0;
        end
    end

    // Receiver: stall at random.
    always @(negedge clk)
    begin
        if (rst_n)
            token_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Predict on every accepted text byte.
    always @(posedge clk)
    begin
        if (rst_n && text_if.valid && text_if.ready)
        begin
            predict_tokens(text_if.char_in);
            accepted_cnt++;
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        token_result_t want;
        if (rst_n && token_if.valid && token_if.ready)
        begin
            if (token_q.size() == 0)
                report_mismatch("result arrived with none expected");
            else
            begin
                want = token_q.pop_front();
                check_field("has_char", token_if.has_char, want.res.has_char);
                check_field("char_out", token_if.char_out, want.res.char_out);
                check_field("token_done", token_if.token_done, want.res.token_done);
                check_field("token_len", token_if.token_len, want.res.token_len);
                check_field("discarded", token_if.discarded, want.res.discarded);
                check_field("text_done", token_if.text_done, want.res.text_done);
                check_field("last", token_if.last, want.last);
            end
            result_cnt++;
        end
    end

    // Guard against a hang.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Wait until every byte was taken and every result has come.
    task automatic drain();
        while (text_q.size() != 0 || accepted_cnt != issued_cnt || token_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(int src_pct, int snk_pct);
        int added;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        added = 0;
        while (added < PHASE_BYTES)
            added += append_fragment();
        drain();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        text_if.valid    = 1'b0;
        text_if.char_in  = CH_NUL;
        token_if.ready   = 1'b0;
        scan_mode        = MODE_IDLE;
        kept_count       = 0;
        issued_cnt       = 0;
        accepted_cnt     = 0;
        result_cnt       = 0;
        mismatch_cnt     = 0;
        cycle_cnt        = 0;
        src_idle_pct     = 0;
        snk_idle_pct     = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed text: NUL between tokens, byte extremes, lone slashes before a
        // word, a blank and a NUL, comments ended by newline and by NUL, quotes
        // with a space, NUL inside a quote and inside a word.
        text_q = '{CH_NUL, 8'h41, 8'h7F, 8'h80, CH_SLASH, 8'h78, 8'h20,
                   CH_SLASH, 8'h20, CH_SLASH, CH_SLASH, 8'hFF, CH_NEWLINE,
                   CH_QUOTE, 8'h20, 8'h21, CH_QUOTE, CH_QUOTE, 8'h71, CH_NUL,
                   CH_SLASH, CH_SLASH, CH_NUL, 8'h7A, CH_NUL, CH_SLASH, CH_NUL};
        drain();

        // Each phase ends with the sender held back until all results are in.
        run_phase(34, 69);
        run_phase(69, 34);
        run_phase(0, 0);

        repeat (DRAIN_WAIT) @(negedge clk);
        if (mismatch_cnt == 0 && token_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/tt_pkg.sv
rtl/tt_if.sv
rtl/tt_front.sv
rtl/tt_queue.sv
rtl/tt_back.sv
rtl/text_tokenizer_with_comments_top.sv
sim/tb.sv
